[src/cchm_pkg.sv]
package cchm_pkg;

    // default sizes
    localparam int DEF_MAX_CLASSES    = 8;
    localparam int DEF_MAX_CATEGORIES = 8;
    localparam int DEF_COUNT_BITS     = 20;

    // fixed field widths
    localparam int FIELD_W   = 3;
    localparam int CFG_W     = 4;
    localparam int PROB_W    = 17;
    localparam int CFG_ADDR_W = 2;

    // stream packing
    localparam int IN_BITS      = 2 * FIELD_W;
    localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS     = 2 * FIELD_W + PROB_W;
    localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

    // front-to-back queue
    localparam int QUEUE_DEPTH = 4;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_CLASSES     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CATEGORIES  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ALLOW_DEGEN = 2'd2;

    typedef enum logic {
        CMD_ADD    = 1'b0,
        CMD_FINISH = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [FIELD_W-1:0] cls;
        logic [FIELD_W-1:0] cat;
    } cchm_op_t;

    // effective sizes, already limited to the built maxima
    typedef struct packed {
        logic [CFG_W-1:0] ncls;
        logic [CFG_W-1:0] ncat;
        logic             allow_degenerate;
    } cchm_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_WR,
        ST_FIN_RD,
        ST_FIN_DIV,
        ST_FIN_OUT
    } back_state_t;

endpackage

[src/cchm_front.sv]
module cchm_front
    import cchm_pkg::*;
(
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               cmd,
    input  logic [FIELD_W-1:0] class_id,
    input  logic [FIELD_W-1:0] category,
    input  cchm_cfg_t          cfg,
    input  logic               q_full,
    output logic               push,
    output cchm_op_t           push_op
);

    logic in_range;
    cmd_t cmd_kind;

    assign cmd_kind = cmd_t'(cmd);
    assign s_tready = !q_full;

    // adds outside the classes or categories in use are dropped here
    assign in_range = (CFG_W'(class_id) < cfg.ncls) && (CFG_W'(category) < cfg.ncat);
    assign push     = s_tvalid && s_tready && ((cmd_kind == CMD_FINISH) || in_range);

    assign push_op.cmd = cmd_kind;
    assign push_op.cls = class_id;
    assign push_op.cat = category;

endmodule

[src/cchm_queue.sv]
module cchm_queue
    import cchm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  cchm_op_t push_op,
    output logic     full,
    input  logic     pop,
    output logic     q_valid,
    output cchm_op_t q_op
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_L = CNT_W'(QUEUE_DEPTH);

    cchm_op_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == DEPTH_L);
    assign q_valid = (count_reg != '0);
    assign q_op    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != DEPTH_L))
        else $error("queue pushed while full");
`endif

endmodule

[src/cchm_div.sv]
module cchm_div
    import cchm_pkg::*;
#(
    parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [COUNT_BITS-1:0] num,
    input  logic [COUNT_BITS-1:0] den,
    output logic                  busy,
    output logic                  done,
    output logic [PROB_W-1:0]     quot
);

    // one quotient bit per cycle, num <= den so the quotient fits in PROB_W bits
    localparam int STEP_W = $clog2(PROB_W + 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PROB_W - 1);

    logic [COUNT_BITS:0]   part_reg;
    logic [COUNT_BITS-1:0] den_reg;
    logic [PROB_W-1:0]     quot_reg;
    logic [STEP_W-1:0]     step_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic                  ge;
    logic [COUNT_BITS:0]   diff;
    logic [COUNT_BITS-1:0] rem;

    always_comb
    begin
        ge   = (part_reg >= {1'b0, den_reg});
        diff = part_reg - {1'b0, den_reg};
        rem  = ge ? diff[COUNT_BITS-1:0] : part_reg[COUNT_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            part_reg <= {1'b0, num};
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            part_reg <= {rem, 1'b0};
            quot_reg <= {quot_reg[PROB_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;

endmodule

[src/cchm_back.sv]
module cchm_back
    import cchm_pkg::*;
#(
    parameter int MAX_CLASSES    = DEF_MAX_CLASSES,
    parameter int MAX_CATEGORIES = DEF_MAX_CATEGORIES,
    parameter int COUNT_BITS     = DEF_COUNT_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cchm_cfg_t          cfg,
    input  logic               q_valid,
    input  cchm_op_t           q_op,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [FIELD_W-1:0] out_class,
    output logic [FIELD_W-1:0] out_category,
    output logic [PROB_W-1:0]  probability,
    output logic               absent,
    output logic               last
);

    localparam int CLS_W  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int CAT_W  = $clog2(MAX_CATEGORIES);
    localparam int DEPTH  = MAX_CLASSES * MAX_CATEGORIES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        sat_inc = (v == COUNT_MAX) ? v : v + COUNT_BITS'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] pair_addr(input logic [CLS_W-1:0] k,
                                                    input logic [CAT_W-1:0] c);
        pair_addr = ADDR_W'(k * MAX_CATEGORIES) + ADDR_W'(c);
    endfunction

    // pair counters, entries read as zero until their valid bit is set
    logic [COUNT_BITS-1:0] mem [DEPTH];
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic [DEPTH-1:0]      valid_reg;
    logic [COUNT_BITS-1:0] totals_reg [MAX_CLASSES];

    back_state_t       state_reg, state_next;
    logic [CLS_W-1:0]  k_reg, k_next;
    logic [CAT_W-1:0]  c_reg, c_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              cnt_zero_reg, cnt_zero_next;
    logic              total_zero_reg, total_zero_next;
    logic              out_valid_reg;

    logic [FIELD_W-1:0] out_class_reg;
    logic [FIELD_W-1:0] out_category_reg;
    logic [PROB_W-1:0]  prob_reg;
    logic               absent_reg;
    logic               last_reg;

    logic [COUNT_BITS-1:0] cnt_now;
    logic [COUNT_BITS-1:0] total_now;
    logic                  is_last;
    logic                  mem_we;
    logic                  clear_all;
    logic                  out_load;
    logic                  div_start;
    logic                  div_busy;
    logic                  div_done;
    logic [PROB_W-1:0]     div_quot;

    assign cnt_now   = valid_reg[addr_reg] ? rd_data_reg : '0;
    assign total_now = totals_reg[k_reg];
    assign is_last   = ((CFG_W'(k_reg) + CFG_W'(1)) == cfg.ncls)
                    && ((CFG_W'(c_reg) + CFG_W'(1)) == cfg.ncat);

    cchm_div #(
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (cnt_now),
        .den   (total_now),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next      = state_reg;
        k_next          = k_reg;
        c_next          = c_reg;
        addr_next       = addr_reg;
        cnt_zero_next   = cnt_zero_reg;
        total_zero_next = total_zero_reg;
        pop             = 1'b0;
        mem_we          = 1'b0;
        clear_all       = 1'b0;
        out_load        = 1'b0;
        div_start       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    pop = 1'b1;
                    if (q_op.cmd == CMD_FINISH)
                    begin
                        if ((cfg.ncls == '0) || (cfg.ncat == '0))
                        begin
                            clear_all = 1'b1;
                        end
                        else
                        begin
                            k_next     = '0;
                            c_next     = '0;
                            addr_next  = '0;
                            state_next = ST_FIN_RD;
                        end
                    end
                    else
                    begin
                        k_next     = CLS_W'(q_op.cls);
                        addr_next  = pair_addr(CLS_W'(q_op.cls), CAT_W'(q_op.cat));
                        state_next = ST_ADD_WR;
                    end
                end
            end
            ST_ADD_WR:
            begin
                mem_we     = 1'b1;
                state_next = ST_IDLE;
            end
            ST_FIN_RD:
            begin
                cnt_zero_next   = (cnt_now == '0);
                total_zero_next = (total_now == '0);
                if (total_now == '0)
                begin
                    state_next = ST_FIN_OUT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_FIN_DIV;
                end
            end
            ST_FIN_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_FIN_OUT;
                end
            end
            ST_FIN_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load = 1'b1;
                    if (is_last)
                    begin
                        clear_all  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        if ((CFG_W'(c_reg) + CFG_W'(1)) == cfg.ncat)
                        begin
                            c_next = '0;
                            k_next = k_reg + CLS_W'(1);
                        end
                        else
                        begin
                            c_next = c_reg + CAT_W'(1);
                        end
                        addr_next  = pair_addr(k_next, c_next);
                        state_next = ST_FIN_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            k_reg          <= '0;
            c_reg          <= '0;
            addr_reg       <= '0;
            cnt_zero_reg   <= 1'b0;
            total_zero_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            valid_reg      <= '0;
            for (int i = 0; i < MAX_CLASSES; i++)
            begin
                totals_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            k_reg          <= k_next;
            c_reg          <= c_next;
            addr_reg       <= addr_next;
            cnt_zero_reg   <= cnt_zero_next;
            total_zero_reg <= total_zero_next;

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (clear_all)
            begin
                valid_reg <= '0;
                for (int i = 0; i < MAX_CLASSES; i++)
                begin
                    totals_reg[i] <= '0;
                end
            end
            else if (mem_we)
            begin
                valid_reg[addr_reg] <= 1'b1;
                totals_reg[k_reg]   <= sat_inc(total_now);
            end
        end
    end

    // counter memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr_reg] <= sat_inc(cnt_now);
        end
        rd_data_reg <= mem[addr_next];
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_class_reg    <= FIELD_W'(k_reg);
            out_category_reg <= FIELD_W'(c_reg);
            prob_reg         <= total_zero_reg ? '0 : div_quot;
            absent_reg       <= cnt_zero_reg && !cfg.allow_degenerate;
            last_reg         <= is_last;
        end
    end

    assign m_tvalid     = out_valid_reg;
    assign out_class    = out_class_reg;
    assign out_category = out_category_reg;
    assign probability  = prob_reg;
    assign absent       = absent_reg;
    assign last         = last_reg;

`ifndef NO_ASSERTIONS
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN_DIV) |-> (div_busy || div_done))
        else $error("waiting on a divider that is not running");

    a_clear_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && is_last) |=> ((valid_reg == '0) && (state_reg == ST_IDLE)))
        else $error("counters not cleared after the last result");
`endif

endmodule

[src/categorical_class_histogram_mstep.sv]
// add beat: taken one per cycle while the 4-entry queue has room; the back end retires an add
//   with a counter read in ST_IDLE, then a saturating write in ST_ADD_WR, before its next pop
// finish beat: each result takes a counter read, a 17-step divider run and an output load;
//   an entry of an empty class skips the divider
// reset: asynchronous, active low; one class, one category, absent flags enabled, counts zero
module categorical_class_histogram_mstep
    import cchm_pkg::*;
#(
    parameter int MAX_CLASSES    = DEF_MAX_CLASSES,
    parameter int MAX_CATEGORIES = DEF_MAX_CATEGORIES,
    parameter int COUNT_BITS     = DEF_COUNT_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // register write port
    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_W-1:0]       cfg_data,

    // observation stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // class_id [2:0], category [5:3], zero pad
    input  logic                   s_tuser,   // cmd: 0 add, 1 finish

    // probability stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // out_class [2:0], out_category [5:3],
                                              // probability [22:6], zero pad
    output logic                   m_tuser,   // absent
    output logic                   m_tlast    // last entry of the run
);

    localparam logic [CFG_W-1:0] MAX_CLS_L = CFG_W'(MAX_CLASSES);
    localparam logic [CFG_W-1:0] MAX_CAT_L = CFG_W'(MAX_CATEGORIES);

    // configuration registers
    logic [CFG_W-1:0] classes_reg;
    logic [CFG_W-1:0] categories_reg;
    logic             allow_degen_reg;

    cchm_cfg_t cfg;

    // front to queue, queue to back
    logic     q_full;
    logic     push;
    cchm_op_t push_op;
    logic     q_valid;
    logic     pop;
    cchm_op_t q_op;

    // back end result fields
    logic [FIELD_W-1:0] out_class;
    logic [FIELD_W-1:0] out_category;
    logic [PROB_W-1:0]  probability;
    logic               absent;
    logic               last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            classes_reg     <= CFG_W'(1);
            categories_reg  <= CFG_W'(1);
            allow_degen_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_CLASSES:     classes_reg     <= cfg_data;
                REG_CATEGORIES:  categories_reg  <= cfg_data;
                REG_ALLOW_DEGEN: allow_degen_reg <= cfg_data[0];
                default:         ;  // writes past the register list are dropped
            endcase
        end
    end

    // sizes above what was built act as the built maximum
    always_comb
    begin
        cfg.ncls             = (classes_reg > MAX_CLS_L) ? MAX_CLS_L : classes_reg;
        cfg.ncat             = (categories_reg > MAX_CAT_L) ? MAX_CAT_L : categories_reg;
        cfg.allow_degenerate = allow_degen_reg;
    end

    // front end: takes beats, drops out-of-range adds, queues the rest
    cchm_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (s_tuser),
        .class_id (s_tdata[FIELD_W-1:0]),
        .category (s_tdata[2*FIELD_W-1:FIELD_W]),
        .cfg      (cfg),
        .q_full   (q_full),
        .push     (push),
        .push_op  (push_op)
    );

    // short queue so the front keeps taking beats while the back end works
    cchm_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .full    (q_full),
        .pop     (pop),
        .q_valid (q_valid),
        .q_op    (q_op)
    );

    // back end: counter updates, finish walk with divider, output register
    cchm_back #(
        .MAX_CLASSES    (MAX_CLASSES),
        .MAX_CATEGORIES (MAX_CATEGORIES),
        .COUNT_BITS     (COUNT_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_valid      (q_valid),
        .q_op         (q_op),
        .pop          (pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .out_class    (out_class),
        .out_category (out_category),
        .probability  (probability),
        .absent       (absent),
        .last         (last)
    );

    // pack result fields, lowest field in the lowest bits
    assign m_tdata = OUT_TDATA_W'({probability, out_category, out_class});
    assign m_tuser = absent;
    assign m_tlast = last;

endmodule

[verif/cchm_checker.sv]
`timescale 1ns / 100ps

module cchm_checker
    import cchm_pkg::*;
#(
    parameter int MAX_CLASSES    = DEF_MAX_CLASSES,
    parameter int MAX_CATEGORIES = DEF_MAX_CATEGORIES,
    parameter int COUNT_BITS     = DEF_COUNT_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // class_id [2:0], category [5:3], zero pad
    input  logic                   s_tuser,   // cmd
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,   // out_class [2:0], out_category [5:3],
                                              // probability [22:6], zero pad
    input  logic                   m_tuser,   // absent
    input  logic                   m_tlast,
    output int                     mismatches,
    output int                     pending,
    output int                     beats_checked,
    output int                     finish_runs
);

    localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;
    localparam longint unsigned PROB_ONE  = 64'd65536;

    typedef struct packed {
        logic [FIELD_W-1:0] cls;
        logic [FIELD_W-1:0] cat;
        logic [PROB_W-1:0]  prob;
        logic               absent;
        logic               last;
    } prob_beat_t;

    logic [CFG_W-1:0] classes_reg;
    logic [CFG_W-1:0] categories_reg;
    logic             degen_ok;

    longint unsigned  pair_count [MAX_CLASSES*MAX_CATEGORIES];
    longint unsigned  class_total [MAX_CLASSES];
    prob_beat_t       prob_q [$];

    function automatic int limit_size(input logic [CFG_W-1:0] v, input int max_v);
        if (int'(v) > max_v)
        begin
            return max_v;
        end
        return int'(v);
    endfunction

    task automatic clear_counts();
        foreach (pair_count[i])
        begin
            pair_count[i] = 0;
        end
        foreach (class_total[i])
        begin
            class_total[i] = 0;
        end
    endtask

    task automatic count_observation(input logic [FIELD_W-1:0] cls,
                                     input logic [FIELD_W-1:0] cat);
        int ncls;
        int ncat;
        int idx;
        ncls = limit_size(classes_reg, MAX_CLASSES);
        ncat = limit_size(categories_reg, MAX_CATEGORIES);
        if (int'(cls) < ncls && int'(cat) < ncat)
        begin
            idx = int'(cls) * MAX_CATEGORIES + int'(cat);
            if (pair_count[idx] < COUNT_MAX)
            begin
                pair_count[idx]++;
            end
            if (class_total[cls] < COUNT_MAX)
            begin
                class_total[cls]++;
            end
        end
    endtask

    // classes outer, categories inner; counters cleared afterwards
    task automatic predict_probabilities();
        int              ncls;
        int              ncat;
        longint unsigned cnt;
        longint unsigned total;
        longint unsigned ratio;
        prob_beat_t      b;
        ncls = limit_size(classes_reg, MAX_CLASSES);
        ncat = limit_size(categories_reg, MAX_CATEGORIES);
        for (int k = 0; k < ncls; k++)
        begin
            total = class_total[k];
            for (int c = 0; c < ncat; c++)
            begin
                cnt   = pair_count[k*MAX_CATEGORIES + c];
                ratio = 0;
                if (total != 0)
                begin
                    ratio = (cnt << 16) / total;
                    if (ratio > PROB_ONE)
                    begin
                        ratio = PROB_ONE;
                    end
                end
                b.cls    = FIELD_W'(k);
                b.cat    = FIELD_W'(c);
                b.prob   = ratio[PROB_W-1:0];
                b.absent = (cnt == 0) && !degen_ok;
                b.last   = (k + 1 == ncls) && (c + 1 == ncat);
                prob_q.push_back(b);
            end
        end
        clear_counts();
    endtask

    task automatic check_field(input string field, input longint unsigned want_v,
                               input longint unsigned got_v);
        if (want_v != got_v)
        begin
            mismatches++;
            $error("%s mismatch: expected %0d, actual %0d", field, want_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        prob_beat_t got;
        prob_beat_t want;
        if (!rst_n)
        begin
            classes_reg    = 4'd1;
            categories_reg = 4'd1;
            degen_ok       = 1'b0;
            clear_counts();
            prob_q.delete();
            mismatches    = 0;
            beats_checked = 0;
            finish_runs   = 0;
        end
        else
        begin
            // result side first: a finish taken at this edge cannot have output yet
            if (m_tvalid && m_tready)
            begin
                got.cls    = m_tdata[FIELD_W-1:0];
                got.cat    = m_tdata[2*FIELD_W-1:FIELD_W];
                got.prob   = m_tdata[2*FIELD_W+PROB_W-1:2*FIELD_W];
                got.absent = m_tuser;
                got.last   = m_tlast;
                beats_checked++;
                if (prob_q.size() == 0)
                begin
                    mismatches++;
                    $error("probability beat with nothing pending: class %0d category %0d",
                           got.cls, got.cat);
                end
                else
                begin
                    want = prob_q.pop_front();
                    check_field("out_class", want.cls, got.cls);
                    check_field("out_category", want.cat, got.cat);
                    check_field("probability", want.prob, got.prob);
                    check_field("absent", want.absent, got.absent);
                    check_field("last", want.last, got.last);
                end
            end

            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_CLASSES:     classes_reg    = cfg_data;
                    REG_CATEGORIES:  categories_reg = cfg_data;
                    REG_ALLOW_DEGEN: degen_ok       = cfg_data[0];
                    default:         ;
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                if (cmd_t'(s_tuser) == CMD_FINISH)
                begin
                    finish_runs++;
                    predict_probabilities();
                end
                else
                begin
                    count_observation(s_tdata[FIELD_W-1:0], s_tdata[2*FIELD_W-1:FIELD_W]);
                end
            end
        end
        pending = prob_q.size();
    end

endmodule

[verif/tb_categorical_class_histogram_mstep.sv]
`timescale 1ns / 100ps

module tb_categorical_class_histogram_mstep;
    import cchm_pkg::*;

    // slowest legal run: every beat a finish of 64 results, each slowed by the divider
    // and by receiver stalls
    localparam int CYCLE_LIMIT  = 5_000_000;
    // time for adds still queued behind the last result to retire
    localparam int DRAIN_CYCLES = 40;
    // long receiver hold-off, long enough for the 4-entry queue to fill
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_BEATS = 300;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   cfg_we   = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [CFG_W-1:0]       cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;   // class_id [2:0], category [5:3], zero pad
    logic                   s_tuser  = 1'b0; // cmd
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;         // out_class [2:0], out_category [5:3],
                                             // probability [22:6], zero pad
    logic                   m_tuser;         // absent
    logic                   m_tlast;

    int mismatches;
    int pending;
    int beats_checked;
    int finish_runs;

    int cycle_count   = 0;
    int counted_beats = 0;   // adds that count plus finishes
    int settings      = 0;

    // per-phase switches: eager sides never idle
    bit tx_eager  = 1'b0;
    bit rx_eager  = 1'b0;
    bit long_hold = 1'b0;

    // sizes as the block sees them, used to shape stimulus and to count beats
    int eff_classes    = 1;
    int eff_categories = 1;

    categorical_class_histogram_mstep uut (.*);

    cchm_checker chk (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_categorical_class_histogram_mstep failed");
            $finish;
        end
    end

    // probability receiver: random stall before each beat, one long hold on request
    initial
    begin
        int stall;
        @(negedge clk);
        forever
        begin
            stall = rx_eager ? 0 : $urandom_range(0, 10);
            if (long_hold)
            begin
                stall += HOLD_CYCLES;
                long_hold = 1'b0;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            @(negedge clk);
        end
    end

    // one observation beat; entered and left at a falling edge
    task automatic send_beat(input cmd_t cmd, input logic [FIELD_W-1:0] cls,
                             input logic [FIELD_W-1:0] cat);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= IN_TDATA_W'({cat, cls});
        // out-of-range adds are dropped by the block and do not count
        if (cmd == CMD_FINISH || (int'(cls) < eff_classes && int'(cat) < eff_categories))
        begin
            counted_beats++;
        end
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    // all three registers, back to back, only while the block is idle
    task automatic set_sizes(input logic [CFG_W-1:0] ncls, input logic [CFG_W-1:0] ncat,
                             input logic deg);
        cfg_we   <= 1'b1;
        cfg_addr <= REG_CLASSES;
        cfg_data <= ncls;
        @(negedge clk);
        cfg_addr <= REG_CATEGORIES;
        cfg_data <= ncat;
        @(negedge clk);
        cfg_addr <= REG_ALLOW_DEGEN;
        cfg_data <= CFG_W'(deg);
        @(negedge clk);
        cfg_we   <= 1'b0;
        @(negedge clk);
        eff_classes    = (int'(ncls) > DEF_MAX_CLASSES) ? DEF_MAX_CLASSES : int'(ncls);
        eff_categories = (int'(ncat) > DEF_MAX_CATEGORIES) ? DEF_MAX_CATEGORIES : int'(ncat);
        settings++;
    endtask

    // stop offering, wait for every pending result, then let queued adds retire
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // mostly small sizes, now and then full size, zero or above the maximum
    function automatic logic [CFG_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
        begin
            return '0;
        end
        if (r == 1)
        begin
            return CFG_W'($urandom_range(9, 15));
        end
        if (r < 5)
        begin
            return CFG_W'(8);
        end
        return CFG_W'($urandom_range(1, 5));
    endfunction

    initial
    begin
        int                 n_adds;
        int                 base;
        logic [FIELD_W-1:0] k;
        logic [FIELD_W-1:0] c;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // --- directed ---
        // reset sizes: one class, one category, absent flags on
        send_beat(CMD_FINISH, 3'd0, 3'd0);   // empty class: probability 0, absent
        send_beat(CMD_ADD, 3'd0, 3'd0);
        send_beat(CMD_ADD, 3'd1, 3'd0);      // class outside range, dropped
        send_beat(CMD_ADD, 3'd0, 3'd7);      // category outside range, dropped
        send_beat(CMD_FINISH, 3'd7, 3'd7);   // single entry at exactly one
        drain();

        // full table, corners of both fields, two thirds / one third split
        set_sizes(4'd8, 4'd8, 1'b0);
        send_beat(CMD_ADD, 3'd7, 3'd7);
        send_beat(CMD_ADD, 3'd0, 3'd0);
        send_beat(CMD_ADD, 3'd0, 3'd0);
        send_beat(CMD_ADD, 3'd0, 3'd7);
        send_beat(CMD_ADD, 3'd7, 3'd0);
        send_beat(CMD_FINISH, 3'd0, 3'd0);
        drain();

        // sizes above the maximum act as 8, absent flags suppressed
        set_sizes(4'd15, 4'd15, 1'b1);
        send_beat(CMD_ADD, 3'd3, 3'd5);
        send_beat(CMD_ADD, 3'd3, 3'd5);
        send_beat(CMD_ADD, 3'd6, 3'd1);
        send_beat(CMD_FINISH, 3'd5, 3'd2);
        drain();

        // zero classes: the finish emits nothing but still clears
        set_sizes(4'd0, 4'd3, 1'b0);
        send_beat(CMD_ADD, 3'd0, 3'd0);
        send_beat(CMD_FINISH, 3'd0, 3'd0);
        drain();
        set_sizes(4'd2, 4'd2, 1'b0);
        send_beat(CMD_FINISH, 3'd2, 3'd5);   // both classes empty after the clear
        drain();

        // --- back-pressure: long receiver hold while the sender keeps offering ---
        set_sizes(4'd8, 4'd8, 1'b0);
        tx_eager = 1'b1;
        repeat (4) send_beat(CMD_ADD, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
        long_hold = 1'b1;
        send_beat(CMD_FINISH, 3'd0, 3'd0);
        repeat (20) send_beat(CMD_ADD, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
        send_beat(CMD_FINISH, 3'd0, 3'd0);
        tx_eager = 1'b0;
        drain();

        // --- random phases: new sizes, a histogram of adds, then a finish ---
        base = counted_beats;
        while (counted_beats - base < RANDOM_BEATS)
        begin
            tx_eager = ($urandom_range(0, 3) == 0);
            rx_eager = ($urandom_range(0, 3) == 0);
            set_sizes(pick_size(), pick_size(), 1'($urandom_range(0, 1)));
            n_adds = $urandom_range(0, 24);
            repeat (n_adds)
            begin
                // mostly in range; the rest lands anywhere and may be dropped
                if ($urandom_range(0, 99) < 85 && eff_classes > 0 && eff_categories > 0)
                begin
                    k = 3'($urandom_range(0, eff_classes - 1));
                    c = 3'($urandom_range(0, eff_categories - 1));
                end
                else
                begin
                    k = 3'($urandom_range(0, 7));
                    c = 3'($urandom_range(0, 7));
                end
                send_beat(CMD_ADD, k, c);
            end
            send_beat(CMD_FINISH, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
            // a second finish right away sees only empty classes
            if ($urandom_range(0, 6) == 0)
            begin
                send_beat(CMD_FINISH, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
            end
            drain();
        end

        $display("covered %0d counted input beats across %0d register settings",
                 counted_beats, settings);
        $display("%0d finish runs produced %0d probability beats, compared in order",
                 finish_runs, beats_checked);
        if (mismatches == 0 && pending == 0)
        begin
            $display("tb_categorical_class_histogram_mstep passed");
        end
        else
        begin
            $display("tb_categorical_class_histogram_mstep failed");
        end
        $finish;
    end

endmodule
